// ===== rtl/core/bsm_pkg.sv =====
package bsm_pkg;

  localparam int WIDTH = 8;
  localparam int PROD_W = 2 * WIDTH;
  // The accumulator carries one sign-guard bit above the operand width.
  localparam int ACC_W = WIDTH + 1;
  localparam int CNT_W = $clog2(WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } bsm_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic add_en;
    logic sub;
  } bsm_cell_ctl_t;

endpackage

// ===== rtl/core/bsm_in_if.sv =====
interface bsm_in_if;
  import bsm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] multiplicand;
  logic signed [WIDTH-1:0] multiplier;

  modport source (output valid, output multiplicand, output multiplier, input ready);
  modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

// ===== rtl/core/bsm_out_if.sv =====
interface bsm_out_if;
  import bsm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PROD_W-1:0] product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface

// ===== rtl/core/bsm_cell.sv =====
module bsm_cell (
  input  logic                   clk,
  input  bsm_pkg::bsm_cell_ctl_t ctl,
  input  logic                   m_load,
  input  logic                   cin,
  output logic                   cout,
  input  logic                   s_left,
  output logic                   s_out,
  output logic                   a_out
);
  import bsm_pkg::*;

  logic a_r;
  logic m_r;
  logic b;
  logic sum;

  // One bit slice of the accumulator: add or subtract the multiplicand bit,
  // then take the left neighbor's result for the arithmetic right shift.
  assign b     = m_r ^ ctl.sub;
  assign sum   = a_r ^ b ^ cin;
  assign cout  = (a_r & b) | (a_r & cin) | (b & cin);
  assign s_out = ctl.add_en ? sum : a_r;
  assign a_out = a_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r <= 1'b0;
      m_r <= m_load;
    end else if (ctl.step) begin
      a_r <= s_left;
    end
  end

endmodule

// ===== rtl/core/booth_signed_multiplier.sv =====
// Radix-2 Booth multiplier for signed two's-complement operands of WIDTH bits,
// returning the exact signed product of 2*WIDTH bits. The accumulator is a
// row of WIDTH+1 bit cells that add or subtract the multiplicand and shift
// right together, one Booth step per clock. An item is taken in by an input
// transfer, runs through the cell row and then moves into the output
// register, and one item is in flight at a time. A finished product waits in
// the output register while the next item is taken in.
module booth_signed_multiplier (
  input  logic clk,
  input  logic rst_n,
  bsm_in_if.sink    in_if,
  bsm_out_if.source out_if
);
  import bsm_pkg::*;

  bsm_state_t  state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] q_r;
  logic             q1_r;
  logic             out_valid_r, out_valid_nxt;
  logic [PROD_W-1:0] out_product_r;

  bsm_cell_ctl_t ctl;
  logic          in_xfer;
  logic          hold_load;
  logic          last_step;
  logic [ACC_W:0]   carry;
  logic [ACC_W-1:0] s_bits;
  logic [ACC_W-1:0] a_bits;
  logic [ACC_W-1:0] m_ext;

  assign in_xfer   = in_if.valid && in_if.ready;
  assign last_step = (cnt_r == CNT_W'(WIDTH - 1));
  assign m_ext     = {in_if.multiplicand[WIDTH-1], in_if.multiplicand};
  assign carry[0]  = ctl.sub;

  genvar i;
  generate
    for (i = 0; i < ACC_W; i++) begin : g_cell
      logic s_left;
      if (i == ACC_W - 1) begin : g_top
        assign s_left = s_bits[i];
      end else begin : g_mid
        assign s_left = s_bits[i+1];
      end
      bsm_cell u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .m_load (m_ext[i]),
        .cin    (carry[i]),
        .cout   (carry[i+1]),
        .s_left (s_left),
        .s_out  (s_bits[i]),
        .a_out  (a_bits[i])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    in_if.ready   = 1'b0;
    hold_load     = 1'b0;
    ctl.load      = 1'b0;
    ctl.step      = 1'b0;
    // Pair 10 subtracts, pair 01 adds, equal pairs leave the accumulator.
    ctl.add_en    = q_r[0] ^ q1_r;
    ctl.sub       = q_r[0];

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_xfer) begin
          ctl.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        ctl.step = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (last_step) begin
          cnt_nxt   = '0;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_if.ready) begin
          hold_load     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_r  <= in_if.multiplier;
      q1_r <= 1'b0;
    end else if (ctl.step) begin
      q1_r <= q_r[0];
      q_r  <= {s_bits[0], q_r[WIDTH-1:1]};
    end
    if (hold_load) begin
      out_product_r <= {a_bits[WIDTH-1:0], q_r};
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.product = out_product_r;

  // The step counter only runs while the cell row is busy.
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> (cnt_r == '0))
    else $error("step counter not cleared outside the run phase");

  // A new product appears only out of the hold state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_HOLD))
    else $error("output became valid without a finished product");

  // A finished product always fits in 2*WIDTH bits, so the guard bit is redundant.
  a_guard: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> (a_bits[ACC_W-1] == a_bits[WIDTH-1]))
    else $error("accumulator guard bit disagrees with product sign");

  // After an input transfer the row runs exactly WIDTH steps.
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && last_step) |=> (state_r == ST_HOLD))
    else $error("run phase did not end after the last step");

endmodule

// ===== dv/booth_signed_multiplier_test.sv =====
module booth_signed_multiplier_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bsm_pkg::*;

  localparam int LATENCY       = WIDTH + 2;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PAIRS  = 700;
  localparam logic [1:0] PAIR_SUB = 2'b10;
  localparam logic [1:0] PAIR_ADD = 2'b01;

  typedef struct packed {
    logic signed [WIDTH-1:0] multiplicand;
    logic signed [WIDTH-1:0] multiplier;
  } factor_pair_t;

  logic clk;
  logic rst_n;

  bsm_in_if  factors_if ();
  bsm_out_if product_if ();

  booth_signed_multiplier DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (factors_if),
    .out_if (product_if)
  );

  factor_pair_t            pending_pairs[$];
  logic signed [PROD_W-1:0] products_due[$];
  int                      mismatch_count = 0;
  int                      burst_left;
  int                      gap_left;
  int                      ready_mode;
  int                      ready_mode_left;
  int                      quiet_cycles;

  // Booth recoding over a WIDTH+1 bit accumulator; the extra bit keeps the
  // subtraction of the most negative multiplicand from overflowing.
  function automatic logic signed [PROD_W-1:0] booth_product(
    input logic signed [WIDTH-1:0] mcand,
    input logic signed [WIDTH-1:0] mplier
  );
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] mcand_ext;
    logic [WIDTH-1:0] q;
    logic             guard;
    acc       = '0;
    q         = mplier;
    guard     = 1'b0;
    mcand_ext = {mcand[WIDTH-1], mcand};
    for (int i = 0; i < WIDTH; i++) begin
      case ({q[0], guard})
        PAIR_SUB: acc = acc - mcand_ext;
        PAIR_ADD: acc = acc + mcand_ext;
        default: ;
      endcase
      guard = q[0];
      q     = {acc[0], q[WIDTH-1:1]};
      acc   = {acc[ACC_W-1], acc[ACC_W-1:1]};
    end
    return {acc[WIDTH-1:0], q};
  endfunction

  function automatic logic signed [WIDTH-1:0] pick_operand();
    logic signed [WIDTH-1:0] value;
    value = WIDTH'($urandom);
    if ($urandom_range(0, 9) < 3) begin
      case ($urandom_range(0, 9))
        0: value = {1'b1, {(WIDTH-1){1'b0}}};
        1: value = {1'b0, {(WIDTH-1){1'b1}}};
        2: value = '0;
        3: value = '1;
        4: value = WIDTH'(1);
        5: value = {1'b1, {(WIDTH-2){1'b0}}, 1'b1};
        6: value = {(WIDTH/2){2'b01}};
        7: value = {(WIDTH/2){2'b10}};
        8: value = WIDTH'(1 << $urandom_range(0, WIDTH - 1));
        default: value = WIDTH'(~(1 << $urandom_range(0, WIDTH - 1)));
      endcase
    end
    return value;
  endfunction

  task automatic queue_pair(input logic signed [WIDTH-1:0] a,
                            input logic signed [WIDTH-1:0] b);
    factor_pair_t pair;
    pair.multiplicand = a;
    pair.multiplier   = b;
    pending_pairs.push_back(pair);
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || factors_if.valid || products_due.size() != 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: issues pairs in bursts with random gaps in between.
  always @(posedge clk) begin
    if (!rst_n) begin
      factors_if.valid <= 1'b0;
      burst_left       <= $urandom_range(1, 40);
      gap_left         <= 0;
    end else begin
      if (factors_if.valid && factors_if.ready)
        products_due.push_back(booth_product(factors_if.multiplicand,
                                             factors_if.multiplier));
      if (!factors_if.valid || factors_if.ready) begin
        if (gap_left > 0) begin
          gap_left         <= gap_left - 1;
          factors_if.valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          factor_pair_t pair;
          pair = pending_pairs.pop_front();
          factors_if.multiplicand <= pair.multiplicand;
          factors_if.multiplier   <= pair.multiplier;
          factors_if.valid        <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          factors_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure switches between a few styles, including none.
  always @(posedge clk) begin
    if (!rst_n) begin
      product_if.ready <= 1'b0;
      ready_mode       <= 0;
      ready_mode_left  <= 100;
    end else begin
      if (ready_mode_left == 0) begin
        ready_mode      <= $urandom_range(0, 3);
        ready_mode_left <= $urandom_range(50, 200);
      end else begin
        ready_mode_left <= ready_mode_left - 1;
      end
      case (ready_mode)
        0: product_if.ready <= 1'b1;
        1: product_if.ready <= ($urandom_range(0, 9) < 7);
        2: product_if.ready <= ($urandom_range(0, 3) == 0);
        default: product_if.ready <= ~product_if.ready;
      endcase
    end
  end

  // Monitor: every product transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && product_if.valid && product_if.ready) begin
      if (products_due.size() == 0) begin
        $error("product: unexpected transfer, actual %0d", product_if.product);
        mismatch_count++;
      end else begin
        logic signed [PROD_W-1:0] predicted;
        predicted = products_due.pop_front();
        if (product_if.product !== predicted) begin
          $error("product: expected %0d, actual %0d", predicted, product_if.product);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (factors_if.valid && factors_if.ready)
        || (product_if.valid && product_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic signed [WIDTH-1:0] corners[5];
    rst_n = 1'b0;

    corners[0] = {1'b1, {(WIDTH-1){1'b0}}};
    corners[1] = '1;
    corners[2] = '0;
    corners[3] = WIDTH'(1);
    corners[4] = {1'b0, {(WIDTH-1){1'b1}}};
    foreach (corners[i])
      foreach (corners[j])
        queue_pair(corners[i], corners[j]);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < RANDOM_PAIRS / 2; n++)
      queue_pair(pick_operand(), pick_operand());
    // Let the pipeline empty completely once before the second half.
    wait_until_drained();
    for (int n = RANDOM_PAIRS / 2; n < RANDOM_PAIRS; n++)
      queue_pair(pick_operand(), pick_operand());

    wait_until_drained();
    repeat (2 * LATENCY) @(negedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
